### rtl/hlcd_pkg.sv
// Shared constants for the header, length and checksum deframer.
`timescale 1ns / 1ps

package hlcd_pkg;

   localparam int MAX_PAYLOAD = 40;
   localparam int NUM_CHANNELS = 10;
   localparam int STORE_DEPTH = 2 * NUM_CHANNELS;

   localparam logic [7:0] HEADER_BYTE = 8'hAA;
   localparam logic [5:0] MAX_PAYLOAD_RESET = 6'd40;

   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

endpackage

### rtl/hlcd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module hlcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/header_length_checksum_deframer.sv
// Top level: byte-stream frame parser with payload RAMs and channel emitter.
//
//   Port group  Direction  Handshake              Contents
//   req_        in         req_valid / req_stall  one received byte
//   rsp_        out        rsp_valid / rsp_stall  frame ID, channel index, value, last
//   csr_        in         csr_wr_en              payload length limit
//
// A byte is taken on req_valid while the parser is hunting or inside a frame.
// After a good checksum each channel is emitted as one payload RAM read followed by
// presenting the result, which is held for as long as the result is stalled.
// The request side is stalled while channels are being emitted.
// Reset is synchronous; the payload RAMs need no clearing pass.
`timescale 1ns / 1ps

module header_length_checksum_deframer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_frame_id,
   output logic [3:0]         rsp_channel_index,
   output logic signed [15:0] rsp_channel_value,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [5:0]         csr_wr_data
);

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_ID,
      ST_LEN,
      ST_DATA,
      ST_SUM,
      ST_FETCH,
      ST_SHOW
   } state_type;

   state_type                     state_ff, state_in;
   logic [5:0]                    max_payload_ff, max_payload_in;
   logic [7:0]                    held_id_ff, held_id_in;
   logic [hlcd_pkg::LEN_W-1:0]    length_ff, length_in;
   logic [hlcd_pkg::LEN_W-1:0]    taken_ff, taken_in;
   logic [7:0]                    sum_ff, sum_in;
   logic [hlcd_pkg::CH_AW-1:0]    chan_ff, chan_in;
   logic [hlcd_pkg::CH_AW-1:0]    last_chan_ff, last_chan_in;

   logic [7:0]                    limit;
   logic [hlcd_pkg::LEN_W-1:0]    half;
   logic [hlcd_pkg::LEN_W-1:0]    taken_next;
   logic                          req_accept;
   logic                          rsp_accept;
   logic                          store_we;
   logic                          even_we;
   logic                          odd_we;
   logic [hlcd_pkg::CH_AW-1:0]    wr_addr;
   logic                          rd_en;
   logic [7:0]                    even_data;
   logic [7:0]                    odd_data;

   assign limit = (8'(max_payload_ff) > 8'(hlcd_pkg::MAX_PAYLOAD)) ?
                  8'(hlcd_pkg::MAX_PAYLOAD) : 8'(max_payload_ff);
   assign half = length_ff >> 1;
   assign taken_next = taken_ff + 1'b1;

   assign req_stall = (state_ff == ST_FETCH) || (state_ff == ST_SHOW);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_SHOW);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign store_we = req_accept && (state_ff == ST_DATA) &&
                     (32'(taken_ff) < hlcd_pkg::STORE_DEPTH);
   assign even_we = store_we && !taken_ff[0];
   assign odd_we = store_we && taken_ff[0];
   assign wr_addr = hlcd_pkg::CH_AW'(taken_ff >> 1);
   assign rd_en = (state_ff == ST_FETCH);

   always_comb begin
      state_in = state_ff;
      max_payload_in = max_payload_ff;
      held_id_in = held_id_ff;
      length_in = length_ff;
      taken_in = taken_ff;
      sum_in = sum_ff;
      chan_in = chan_ff;
      last_chan_in = last_chan_ff;

      if (csr_wr_en) begin
         max_payload_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_HUNT: begin
            if (req_accept && (req_rx_data == hlcd_pkg::HEADER_BYTE)) begin
               sum_in = hlcd_pkg::HEADER_BYTE;
               state_in = ST_ID;
            end
         end
         ST_ID: begin
            if (req_accept) begin
               held_id_in = req_rx_data;
               sum_in = sum_ff + req_rx_data;
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (req_accept) begin
               if (req_rx_data > limit) begin
                  state_in = ST_HUNT;
               end else begin
                  length_in = hlcd_pkg::LEN_W'(req_rx_data);
                  taken_in = '0;
                  sum_in = sum_ff + req_rx_data;
                  state_in = (req_rx_data == 8'd0) ? ST_SUM : ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (req_accept) begin
               sum_in = sum_ff + req_rx_data;
               taken_in = taken_next;
               if (taken_next >= length_ff) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (req_accept) begin
               state_in = ST_HUNT;
               if ((req_rx_data == sum_ff) && (half != '0)) begin
                  chan_in = '0;
                  if (32'(half) > hlcd_pkg::NUM_CHANNELS) begin
                     last_chan_in = hlcd_pkg::CH_AW'(hlcd_pkg::NUM_CHANNELS - 1);
                  end else begin
                     last_chan_in = hlcd_pkg::CH_AW'(half - 1'b1);
                  end
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_accept) begin
               if (chan_ff == last_chan_ff) begin
                  state_in = ST_HUNT;
               end else begin
                  chan_in = chan_ff + 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         max_payload_ff <= hlcd_pkg::MAX_PAYLOAD_RESET;
         held_id_ff <= '0;
         length_ff <= '0;
         taken_ff <= '0;
         sum_ff <= '0;
         chan_ff <= '0;
         last_chan_ff <= '0;
      end else begin
         state_ff <= state_in;
         max_payload_ff <= max_payload_in;
         held_id_ff <= held_id_in;
         length_ff <= length_in;
         taken_ff <= taken_in;
         sum_ff <= sum_in;
         chan_ff <= chan_in;
         last_chan_ff <= last_chan_in;
      end
   end

   hlcd_ram #(
      .WIDTH(8),
      .DEPTH(hlcd_pkg::NUM_CHANNELS)
   ) u_even_ram (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (wr_addr),
      .wr_data (req_rx_data),
      .rd_en   (rd_en),
      .rd_addr (chan_ff),
      .rd_data (even_data)
   );

   hlcd_ram #(
      .WIDTH(8),
      .DEPTH(hlcd_pkg::NUM_CHANNELS)
   ) u_odd_ram (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (wr_addr),
      .wr_data (req_rx_data),
      .rd_en   (rd_en),
      .rd_addr (chan_ff),
      .rd_data (odd_data)
   );

   assign rsp_frame_id = held_id_ff;
   assign rsp_channel_index = 4'(chan_ff);
   assign rsp_channel_value = signed'({even_data, odd_data});
   assign rsp_last = (chan_ff == last_chan_ff);

endmodule
